[design/pkfwrl_pkg.sv]
// Shared constants, types and a helper function for the per-key fixed-window
// rate limiter. No dependencies; every other design file uses this package.
package pkfwrl_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int KEY_W             = 32;
   localparam int CNT_W             = 16;
   localparam int TIME_W            = 32;
   localparam int CFG_W             = 16;
   localparam int CSR_IDX_W         = 2;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_REQUESTS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_TICKS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_INTERVAL = 2'd2;

   localparam logic [CFG_W-1:0] MAX_REQUESTS_RST   = 16'd100;
   localparam logic [CFG_W-1:0] WINDOW_TICKS_RST   = 16'd60;
   localparam logic [CFG_W-1:0] SWEEP_INTERVAL_RST = 16'd60;

   localparam logic REQ_CLIENT     = 1'b0;
   localparam logic REQ_TICK       = 1'b1;
   localparam logic VERDICT_ALLOW  = 1'b0;
   localparam logic VERDICT_REJECT = 1'b1;

   typedef struct packed {
      logic [CFG_W-1:0] max_requests;
      logic [CFG_W-1:0] window_ticks;
      logic [CFG_W-1:0] sweep_interval;
   } cfg_type;

   typedef struct packed {
      logic             is_tick;
      logic [KEY_W-1:0] key;
   } queue_item_type;

   typedef struct packed {
      logic           valid;
      queue_item_type item;
   } queue_out_type;

   typedef struct packed {
      logic pop;
      logic init_busy;
   } back_stat_type;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [CNT_W-1:0]  count;
      logic [TIME_W-1:0] window_end;
   } entry_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_DONE
   } state_type;

   // True when a lies strictly after b on the wrapping time line.
   function automatic logic is_after(input logic [TIME_W-1:0] a,
                                     input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] d;
      d = a - b;
      return (d != '0) && !d[TIME_W-1];
   endfunction

endpackage

[design/pkfwrl_if.sv]
// Request and response channel interfaces of the rate limiter.
// Depends on pkfwrl_pkg for field widths.
interface pkfwrl_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [pkfwrl_pkg::KEY_W-1:0] client_key;

   modport source (output valid, output req_type, output client_key, input ready);
   modport sink   (input valid, input req_type, input client_key, output ready);
endinterface

interface pkfwrl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         verdict;
   logic                         untracked;
   logic [pkfwrl_pkg::CNT_W-1:0] count_now;

   modport source (output valid, output verdict, output untracked, output count_now,
                   input ready);
   modport sink   (input valid, input verdict, input untracked, input count_now,
                   output ready);
endinterface

[design/pkfwrl_front.sv]
// Front end: accepts requests, decodes ticks from client requests and queues them
// for the table engine. Depends on pkfwrl_pkg and pkfwrl_req_if.
module pkfwrl_front (
   input  logic                      clock,
   input  logic                      reset,
   pkfwrl_req_if.sink                req_bus,
   input  pkfwrl_pkg::back_stat_type stat,
   output pkfwrl_pkg::queue_out_type qout
);
   import pkfwrl_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

   queue_item_type    store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] fill_ff, fill_in;
   logic              push;
   queue_item_type    item;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // No request is taken while the table is being cleared after reset.
   assign req_bus.ready = (fill_ff != CNT_QW'(QUEUE_DEPTH)) && !stat.init_busy;
   assign push          = req_bus.valid && req_bus.ready;
   assign item.is_tick  = (req_bus.req_type == REQ_TICK);
   assign item.key      = req_bus.client_key;

   assign qout.valid = (fill_ff != '0);
   assign qout.item  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = stat.pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !stat.pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && stat.pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

[design/pkfwrl_back.sv]
// Table engine: keeps time, sweeps and looks up the key table in one pass and
// drives the response register. Depends on pkfwrl_pkg and pkfwrl_rsp_if.
module pkfwrl_back #(
   parameter int TABLE_ENTRIES = pkfwrl_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pkfwrl_pkg::cfg_type       cfg,
   input  pkfwrl_pkg::queue_out_type qout,
   output pkfwrl_pkg::back_stat_type stat,
   pkfwrl_rsp_if.source              rsp_bus
);
   import pkfwrl_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   entry_type         mem [TABLE_ENTRIES];
   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa, mem_ra;
   entry_type         mem_wd;
   entry_type         rd_data_ff;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [TIME_W-1:0] last_sweep_ff, last_sweep_in;
   logic              sweep_ff, sweep_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [CNT_W-1:0]  hit_count_ff, hit_count_in;
   logic [TIME_W-1:0] hit_wend_ff, hit_wend_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              verdict_ff, verdict_in;
   logic              untracked_ff, untracked_in;
   logic [CNT_W-1:0]  count_now_ff, count_now_in;

   logic              expired, eff_valid;
   logic [TIME_W-1:0] new_wend, since_sweep;
   entry_type         fresh;

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.verdict   = verdict_ff;
   assign rsp_bus.untracked = untracked_ff;
   assign rsp_bus.count_now = count_now_ff;

   assign expired     = is_after(time_ff, rd_data_ff.window_end);
   assign eff_valid   = rd_data_ff.valid && !(sweep_ff && expired);
   assign new_wend    = time_ff + TIME_W'(cfg.window_ticks);
   assign since_sweep = time_ff - last_sweep_ff;

   always_comb begin
      fresh.valid      = 1'b1;
      fresh.key        = key_ff;
      fresh.count      = CNT_W'(1);
      fresh.window_end = new_wend;
   end

   always_comb begin
      state_in       = state_ff;
      scan_in        = scan_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_idx_ff;
      time_in        = time_ff;
      last_sweep_in  = last_sweep_ff;
      sweep_in       = sweep_ff;
      key_in         = key_ff;
      hit_found_in   = hit_found_ff;
      hit_idx_in     = hit_idx_ff;
      hit_count_in   = hit_count_ff;
      hit_wend_in    = hit_wend_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      verdict_in     = verdict_ff;
      untracked_in   = untracked_ff;
      count_now_in   = count_now_ff;
      mem_we         = 1'b0;
      mem_wa         = rd_idx_ff;
      mem_wd         = rd_data_ff;
      mem_ra         = scan_ff;
      stat.pop       = 1'b0;
      stat.init_busy = (state_ff == ST_INIT);

      // Entry read during the pass: the sweep frees it first, then the lookup sees it.
      if (rd_vld_ff) begin
         if (sweep_ff && rd_data_ff.valid && expired) begin
            mem_we       = 1'b1;
            mem_wd.valid = 1'b0;
         end
         if (eff_valid && (rd_data_ff.key == key_ff) && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = rd_idx_ff;
            hit_count_in = rd_data_ff.count;
            hit_wend_in  = rd_data_ff.window_end;
         end
         if (!eff_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
      end

      case (state_ff)
         ST_INIT: begin
            mem_we  = 1'b1;
            mem_wa  = scan_ff;
            mem_wd  = '0;
            scan_in = scan_ff + 1'b1;
            if (scan_ff == LAST_IDX) begin
               scan_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (qout.valid) begin
               stat.pop = 1'b1;
               if (qout.item.is_tick) begin
                  time_in = time_ff + 1'b1;
               end else begin
                  key_in        = qout.item.key;
                  hit_found_in  = 1'b0;
                  free_found_in = 1'b0;
                  scan_in       = '0;
                  sweep_in      = (since_sweep >= TIME_W'(cfg.sweep_interval));
                  if (since_sweep >= TIME_W'(cfg.sweep_interval)) begin
                     last_sweep_in = time_ff;
                  end
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_vld_in = 1'b1;
            rd_idx_in = scan_ff;
            scan_in   = scan_ff + 1'b1;
            if (scan_ff == LAST_IDX) begin
               scan_in  = '0;
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               verdict_in   = VERDICT_ALLOW;
               untracked_in = 1'b0;
               count_now_in = CNT_W'(1);
               state_in     = ST_IDLE;
               if (!hit_found_ff) begin
                  if (free_found_ff) begin
                     mem_we = 1'b1;
                     mem_wa = free_idx_ff;
                     mem_wd = fresh;
                  end else begin
                     untracked_in = 1'b1;
                  end
               end else if (is_after(time_ff, hit_wend_ff)) begin
                  mem_we = 1'b1;
                  mem_wa = hit_idx_ff;
                  mem_wd = fresh;
               end else if (hit_count_ff >= cfg.max_requests) begin
                  verdict_in   = VERDICT_REJECT;
                  count_now_in = hit_count_ff;
               end else begin
                  mem_we             = 1'b1;
                  mem_wa             = hit_idx_ff;
                  mem_wd.valid       = 1'b1;
                  mem_wd.key         = key_ff;
                  mem_wd.count       = hit_count_ff + 1'b1;
                  mem_wd.window_end  = hit_wend_ff;
                  count_now_in       = hit_count_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         scan_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         time_ff       <= '0;
         last_sweep_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         rd_vld_ff     <= rd_vld_in;
         time_ff       <= time_in;
         last_sweep_ff <= last_sweep_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      sweep_ff      <= sweep_in;
      key_ff        <= key_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_count_ff  <= hit_count_in;
      hit_wend_ff   <= hit_wend_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      verdict_ff    <= verdict_in;
      untracked_ff  <= untracked_in;
      count_now_ff  <= count_now_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

endmodule

[design/per_key_fixed_window_rate_limiter.sv]
// Per-key fixed-window rate limiter, top level.
// Requests arrive on req_bus: req_type 0 carries a client request for client_key,
// req_type 1 is one time tick. Each client request yields one response on rsp_bus
// (verdict, untracked flag, count after the request); a tick yields none.
// The user writes registers max_requests, window_ticks and sweep_interval through
// csr_we/csr_index/csr_wdata only while the block is idle; the block does not enforce it.
// A two-entry queue sits between the front end and the table engine, so requests
// keep being taken while a response waits on a stalled receiver.
// A tick is handled in the engine's idle state alone; a client request takes the
// single pass over the table memory (one read port, one entry per cycle) that
// sweeps and looks up together. The engine takes the next queued item only back in idle.
// An accepted request passes through the queue and the engine's idle, scan, last and
// done states before its response is registered.
// When rsp_bus.ready is low the response register holds, the engine waits in its
// final step and the queue fills; req_bus.ready then drops.
// After reset the engine clears the table memory, one entry per cycle, over all
// TABLE_ENTRIES entries; req_bus.ready stays low during that pass.
// Dependencies: pkfwrl_pkg, pkfwrl_if, pkfwrl_front, pkfwrl_back.
module per_key_fixed_window_rate_limiter #(
   parameter int TABLE_ENTRIES = pkfwrl_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   pkfwrl_req_if.sink                       req_bus,
   pkfwrl_rsp_if.source                     rsp_bus,
   input  logic                             csr_we,
   input  logic [pkfwrl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pkfwrl_pkg::CFG_W-1:0]     csr_wdata
);
   import pkfwrl_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   queue_out_type qout;
   back_stat_type stat;

   // Writes to an index beyond the register list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_REQUESTS:   cfg_in.max_requests   = csr_wdata;
            CSR_WINDOW_TICKS:   cfg_in.window_ticks   = csr_wdata;
            CSR_SWEEP_INTERVAL: cfg_in.sweep_interval = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_requests   <= MAX_REQUESTS_RST;
         cfg_ff.window_ticks   <= WINDOW_TICKS_RST;
         cfg_ff.sweep_interval <= SWEEP_INTERVAL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pkfwrl_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .stat    (stat),
      .qout    (qout)
   );

   pkfwrl_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .qout    (qout),
      .stat    (stat),
      .rsp_bus (rsp_bus)
   );

endmodule

[tb/per_key_fixed_window_rate_limiter_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the per-key fixed-window rate limiter.
// Depends on pkfwrl_pkg, pkfwrl_if and the per_key_fixed_window_rate_limiter top level.
module per_key_fixed_window_rate_limiter_tb;
   import pkfwrl_pkg::*;

   localparam int SLOTS          = TABLE_ENTRIES_DEF;
   localparam int HOLD_OFF       = SLOTS + 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SHOWN_ERRORS   = 10;

   // Index 3 decodes to no register; a write there must leave the block unchanged.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic             verdict;
      logic             untracked;
      logic [CNT_W-1:0] count_now;
   } verdict_rec_type;

   // Tracks the limiter's table and clock, predicts one verdict per client
   // request and compares the responses against those predictions in order.
   class admission_scoreboard;
      logic [CFG_W-1:0]  limit_per_window;
      logic [CFG_W-1:0]  window_len;
      logic [CFG_W-1:0]  sweep_gap;
      logic              slot_used  [SLOTS];
      logic [KEY_W-1:0]  slot_key   [SLOTS];
      logic [CNT_W-1:0]  slot_count [SLOTS];
      logic [TIME_W-1:0] slot_end   [SLOTS];
      logic [TIME_W-1:0] ticks;
      logic [TIME_W-1:0] last_sweep;
      verdict_rec_type   expected_verdicts[$];
      int                errors;

      function new();
         limit_per_window = MAX_REQUESTS_RST;
         window_len       = WINDOW_TICKS_RST;
         sweep_gap        = SWEEP_INTERVAL_RST;
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         ticks      = '0;
         last_sweep = '0;
         errors     = 0;
      endfunction

      // A point lies after another when the forward distance is nonzero and
      // less than half of the time range.
      function bit later_than(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
         logic [TIME_W-1:0] d;
         d = a - b;
         return (d != '0) && (d <= {1'b0, {(TIME_W-1){1'b1}}});
      endfunction

      function void set_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CFG_W-1:0] value);
         case (idx)
            CSR_MAX_REQUESTS:   limit_per_window = value;
            CSR_WINDOW_TICKS:   window_len = value;
            CSR_SWEEP_INTERVAL: sweep_gap = value;
            default: ;
         endcase
      endfunction

      function void note_request(input logic kind, input logic [KEY_W-1:0] key);
         int              hit;
         int              free_idx;
         verdict_rec_type v;
         if (kind == REQ_TICK) begin
            ticks = ticks + 1'b1;
         end else begin
            if (ticks - last_sweep >= sweep_gap) begin
               last_sweep = ticks;
               for (int i = 0; i < SLOTS; i++)
                  if (slot_used[i] && later_than(ticks, slot_end[i])) slot_used[i] = 1'b0;
            end
            hit      = -1;
            free_idx = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[i]) begin
                  if (hit < 0 && slot_key[i] == key) hit = i;
               end else if (free_idx < 0) begin
                  free_idx = i;
               end
            end
            v.verdict   = VERDICT_ALLOW;
            v.untracked = 1'b0;
            v.count_now = CNT_W'(1);
            if (hit < 0) begin
               if (free_idx < 0) begin
                  v.untracked = 1'b1;
               end else begin
                  slot_used[free_idx]  = 1'b1;
                  slot_key[free_idx]   = key;
                  slot_count[free_idx] = CNT_W'(1);
                  slot_end[free_idx]   = ticks + window_len;
               end
            end else if (later_than(ticks, slot_end[hit])) begin
               slot_count[hit] = CNT_W'(1);
               slot_end[hit]   = ticks + window_len;
            end else if (slot_count[hit] >= limit_per_window) begin
               v.verdict   = VERDICT_REJECT;
               v.count_now = slot_count[hit];
            end else begin
               slot_count[hit] = slot_count[hit] + 1'b1;
               v.count_now     = slot_count[hit];
            end
            expected_verdicts.push_back(v);
         end
      endfunction

      function void check_verdict(input logic verdict, input logic untracked,
                                  input logic [CNT_W-1:0] count_now);
         verdict_rec_type want;
         if (expected_verdicts.size() == 0) begin
            errors++;
            if (errors <= SHOWN_ERRORS)
               $display("%0t: response with none expected: v=%0d u=%0d count=%0d",
                        $time, verdict, untracked, count_now);
         end else begin
            want = expected_verdicts.pop_front();
            if (verdict !== want.verdict || untracked !== want.untracked ||
                count_now !== want.count_now) begin
               errors++;
               if (errors <= SHOWN_ERRORS)
                  $display({"%0t: mismatch: expected v=%0d u=%0d count=%0d, ",
                            "got v=%0d u=%0d count=%0d"},
                           $time, want.verdict, want.untracked, want.count_now,
                           verdict, untracked, count_now);
            end
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   pkfwrl_req_if req_bus ();
   pkfwrl_rsp_if rsp_bus ();

   admission_scoreboard sb;
   int  sent;
   bit  sender_calm;
   bit  sink_calm;
   int  quiet;

   per_key_fixed_window_rate_limiter #(
      .TABLE_ENTRIES(SLOTS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Valid is left high after a request so that back-to-back requests never
   // lower and raise it within the same time step.
   task automatic send_item(input logic kind, input logic [KEY_W-1:0] key);
      int gap;
      if (sent % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      gap = sender_calm ? 0 : $urandom_range(0, 8);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= kind;
      req_bus.client_key <= key;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(kind, key);
      sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.expected_verdicts.size() != 0) @(posedge clock);
   endtask

   // Ticks produce no response, so the engine may still be busy with one
   // after the last response; wait out its latency as well.
   task automatic settle();
      drain();
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_register(idx, value);
   endtask

   task automatic configure(input logic [CFG_W-1:0] max_req, input logic [CFG_W-1:0] win,
                            input logic [CFG_W-1:0] sweep);
      settle();
      csr_write(CSR_MAX_REQUESTS, max_req);
      csr_write(CSR_WINDOW_TICKS, win);
      csr_write(CSR_SWEEP_INTERVAL, sweep);
   endtask

   // Most requests draw from a small pool of keys so that counts, limits and
   // window expiry are exercised; a few use fully random keys.
   task automatic random_phase(input logic [CFG_W-1:0] max_req, input logic [CFG_W-1:0] win,
                               input logic [CFG_W-1:0] sweep, input int pool_size,
                               input int tick_pct, input int count);
      logic [KEY_W-1:0] pool [96];
      configure(max_req, win, sweep);
      foreach (pool[i]) pool[i] = $urandom;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) drain();
         if ($urandom_range(0, 99) < tick_pct)
            send_item(REQ_TICK, $urandom);
         else if ($urandom_range(0, 9) == 0)
            send_item(REQ_CLIENT, $urandom);
         else
            send_item(REQ_CLIENT, pool[$urandom_range(0, pool_size - 1)]);
      end
   endtask

   initial begin : response_sink
      int stall;
      int taken;
      rsp_bus.ready = 1'b0;
      taken         = 0;
      wait (reset == 1'b0);
      forever begin
         if (taken % 40 == 0) sink_calm = ($urandom_range(0, 3) == 0);
         stall = sink_calm ? 0 : $urandom_range(0, 8);
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         sb.check_verdict(rsp_bus.verdict, rsp_bus.untracked, rsp_bus.count_now);
         taken++;
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b1 || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      sb                 = new();
      sent               = 0;
      sender_calm        = 1'b0;
      sink_calm          = 1'b0;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_MAX_REQUESTS;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_CLIENT;
      req_bus.client_key = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: new keys, a repeated key and both key extremes.
      send_item(REQ_CLIENT, 32'h0000_0000);
      send_item(REQ_CLIENT, 32'hFFFF_FFFF);
      send_item(REQ_CLIENT, 32'h0000_0000);
      send_item(REQ_TICK, 32'hFFFF_FFFF);
      send_item(REQ_CLIENT, 32'hA5A5_5A5A);
      send_item(REQ_CLIENT, 32'hFFFF_FFFF);

      // Limit of one: an existing key is rejected, and a sweep interval of one
      // tick frees a key whose one-tick window has passed.
      configure(16'd1, 16'd1, 16'd1);
      csr_write(CSR_SPARE, 16'h0000);
      send_item(REQ_CLIENT, 32'h0000_0000);
      send_item(REQ_CLIENT, 32'h1234_5678);
      send_item(REQ_CLIENT, 32'h1234_5678);
      send_item(REQ_TICK, 32'h0000_0000);
      send_item(REQ_TICK, 32'h0000_0000);
      send_item(REQ_CLIENT, 32'h1234_5678);

      // No sweeps: an expired key found in the table restarts its window.
      configure(16'd65535, 16'd2, 16'd65535);
      send_item(REQ_CLIENT, 32'h0F0F_0F0F);
      send_item(REQ_TICK, 32'h0000_0000);
      send_item(REQ_TICK, 32'h0000_0000);
      send_item(REQ_TICK, 32'h0000_0000);
      send_item(REQ_CLIENT, 32'h0F0F_0F0F);
      send_item(REQ_CLIENT, 32'h0F0F_0F0F);

      random_phase(16'd3, 16'd10, 16'd5, 8, 30, 155);
      // More keys than slots and no sweeps, so the table fills with stale entries.
      random_phase(16'd2, 16'd4, 16'd65535, 90, 15, 155);
      random_phase(16'd1, 16'd1, 16'd1, 4, 40, 155);
      random_phase(16'd5, 16'd20, 16'd10, 70, 15, 155);
      random_phase(16'd65535, 16'd1, 16'd1, 16, 30, 155);
      random_phase(16'd65535, 16'd65535, 16'd65535, 90, 5, 155);

      settle();
      if (sb.errors == 0 && sb.expected_verdicts.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
